// ===== rtl/core/asc_pkg.sv =====
// Shared types, codes and helpers for the alarm snooze controller.
package asc_pkg;

    localparam logic [9:0]  LED_FULL       = 10'h3FF;
    localparam logic [1:0]  PREDELAY_TICKS = 2'd3;
    localparam int          CFG_IDX_W      = 3;
    localparam int          CFG_DATA_W     = 8;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_INIT    = 3'd1,
        PH_ON      = 3'd2,
        PH_SNOOZE  = 3'd3,
        PH_DISABLE = 3'd4,
        PH_WAIT    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        REQ_POLL     = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_DISABLE  = 2'd2,
        REQ_INIT_DONE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_ENABLE   = 3'd0,
        CFG_ALARM_HOUR     = 3'd1,
        CFG_ALARM_MINUTE   = 3'd2,
        CFG_RING_TRIES     = 3'd3,
        CFG_RING_MINUTES   = 3'd4,
        CFG_SNOOZE_MINUTES = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic       alarm_enable;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [7:0] ring_tries;
        logic [7:0] ring_minutes;
        logic [7:0] snooze_minutes;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [13:0] ring_timer;
        logic [13:0] snooze_timer;
        logic [7:0]  tries_left;
        logic [1:0]  predelay_count;
        logic [7:0]  chosen_sound;
        logic [9:0]  led_duty;
    } ctx_t;

    typedef struct packed {
        logic       sound_busy;
        logic [7:0] random_sound;
        logic [7:0] wanted_sound;
        logic [5:0] now_minute;
        logic [4:0] now_hour;
        req_t       req_type;
    } item_t;

    typedef struct packed {
        logic [9:0] led_level;
        logic       force_bright;
        logic       stop_sound;
        logic       announce_time;
        logic [7:0] sound_index;
        logic       start_sound;
        phase_t     alarm_state;
    } res_t;

    // minutes to seconds: x*60 = x*64 - x*4
    function automatic logic [13:0] min_to_sec(input logic [7:0] mins);
        logic [13:0] wide;
        wide = {6'd0, mins};
        return (wide << 6) - (wide << 2);
    endfunction

endpackage

// ===== rtl/core/asc_step.sv =====
// Next-state and result logic for one event transaction.
module asc_step
    import asc_pkg::*;
(
    input  cfg_t  cfg,
    input  ctx_t  cur,
    input  item_t item,
    output ctx_t  nxt,
    output res_t  res
);

    logic time_match;
    logic snooze_on;

    assign time_match = (cfg.alarm_hour == item.now_hour) &&
                        (cfg.alarm_minute == item.now_minute);
    assign snooze_on  = (cfg.snooze_minutes != 8'd0);

    always_comb
    begin
        nxt = cur;
        res = '0;

        case (item.req_type)
            REQ_POLL:
            begin
                // alarm fire / forced disable before the phase update
                if (cfg.alarm_enable)
                begin
                    if (time_match && (cur.phase == PH_OFF))
                    begin
                        nxt.phase          = PH_INIT;
                        nxt.predelay_count = PREDELAY_TICKS;
                    end
                end
                else if (cur.phase != PH_OFF)
                begin
                    nxt.phase = PH_DISABLE;
                end

                unique case (nxt.phase)
                    PH_INIT:
                    begin
                        if (nxt.predelay_count == 2'd0)
                        begin
                            nxt.tries_left   = (cfg.ring_tries != 8'd0) ? cfg.ring_tries : 8'd1;
                            nxt.ring_timer   = min_to_sec(cfg.ring_minutes);
                            nxt.phase        = PH_ON;
                            nxt.chosen_sound = (item.wanted_sound == 8'd0) ?
                                               item.random_sound : item.wanted_sound - 8'd1;
                            res.announce_time = 1'b1;
                        end
                    end
                    PH_ON:
                    begin
                        if (cur.ring_timer != 14'd0)
                        begin
                            res.start_sound  = ~item.sound_busy;
                            res.force_bright = 1'b1;
                        end
                        else if (snooze_on && (cur.tries_left > 8'd1))
                        begin
                            nxt.tries_left   = cur.tries_left - 8'd1;
                            res.stop_sound   = 1'b1;
                            nxt.snooze_timer = min_to_sec(cfg.snooze_minutes);
                            nxt.phase        = PH_SNOOZE;
                        end
                        else
                        begin
                            if (snooze_on && (cur.tries_left != 8'd0))
                                nxt.tries_left = cur.tries_left - 8'd1;
                            nxt.phase = PH_DISABLE;
                        end
                    end
                    PH_SNOOZE:
                    begin
                        if (cur.snooze_timer == 14'd0)
                        begin
                            nxt.ring_timer    = min_to_sec(cfg.ring_minutes);
                            nxt.phase         = PH_ON;
                            res.announce_time = 1'b1;
                        end
                    end
                    PH_DISABLE:
                    begin
                        res.stop_sound = 1'b1;
                        nxt.phase      = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        if (!cfg.alarm_enable || !time_match)
                            nxt.phase = PH_OFF;
                    end
                    default:
                    begin
                    end
                endcase

                // LED: full while ringing or in predelay, else fade one step
                if ((nxt.phase == PH_ON) || (nxt.phase == PH_INIT))
                    nxt.led_duty = LED_FULL;
                else if (cur.led_duty != 10'd0)
                    nxt.led_duty = cur.led_duty - 10'd1;
            end
            REQ_TICK:
            begin
                if (cur.phase == PH_INIT)
                begin
                    if (cur.predelay_count != 2'd0)
                        nxt.predelay_count = cur.predelay_count - 2'd1;
                end
                else if (cur.phase == PH_ON)
                begin
                    if (cur.ring_timer != 14'd0)
                        nxt.ring_timer = cur.ring_timer - 14'd1;
                end
                else if (cur.phase == PH_SNOOZE)
                begin
                    if (cur.snooze_timer != 14'd0)
                        nxt.snooze_timer = cur.snooze_timer - 14'd1;
                end
            end
            REQ_DISABLE:
            begin
                if ((cur.phase == PH_ON) && snooze_on)
                    nxt.ring_timer = 14'd0;
                else
                    nxt.phase = PH_DISABLE;
            end
            default:
            begin
                nxt.predelay_count = 2'd0;
            end
        endcase

        res.alarm_state = nxt.phase;
        res.sound_index = nxt.chosen_sound;
        res.led_level   = nxt.led_duty;
    end

endmodule

// ===== rtl/core/alarm_snooze_controller_core.sv =====
// Alarm snooze controller top level: config registers, input/result stages, context.
// Throughput: one event per cycle unless the output stalls; the event logic is one short
//   pass of compares, decrements and a shift-subtract minutes-to-seconds scale between two
//   registers: the input register, then the result register, which holds until taken.
// Reset (rst_n low, async): both stages empty, phase off, timers, tries, sound and
//   LED cleared; config returns to disabled, 00:00, 3 tries, 5 ring and 5 snooze minutes.
module alarm_snooze_controller_core
    import asc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // event stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [4:0] now_hour, [10:5] now_minute, [18:11] wanted_sound,
    // [26:19] random_sound, [27] sound_busy, [31:28] zero
    input  logic [31:0]           s_tdata,
    // [1:0] req_type
    input  logic [1:0]            s_tuser,

    // result stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] alarm_state, [3] start_sound, [11:4] sound_index, [12] announce_time,
    // [13] stop_sound, [14] force_bright, [24:15] led_level, [31:25] zero
    output logic [31:0]           m_tdata,

    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    ctx_t  ctx_reg;
    ctx_t  ctx_next;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  out_res_reg;
    res_t  res_next;
    logic  out_valid_reg;

    logic  s_accept;
    logic  advance;     // result register can load this cycle
    logic  process;     // input-stage transaction moves to result stage

    // config writes land directly in the registers, so the channel never stalls
    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_enable   <= 1'b0;
            cfg_reg.alarm_hour     <= 5'd0;
            cfg_reg.alarm_minute   <= 6'd0;
            cfg_reg.ring_tries     <= 8'd3;
            cfg_reg.ring_minutes   <= 8'd5;
            cfg_reg.snooze_minutes <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALARM_ENABLE:   cfg_reg.alarm_enable   <= cfg_data[0];
                CFG_ALARM_HOUR:     cfg_reg.alarm_hour     <= cfg_data[4:0];
                CFG_ALARM_MINUTE:   cfg_reg.alarm_minute   <= cfg_data[5:0];
                CFG_RING_TRIES:     cfg_reg.ring_tries     <= cfg_data;
                CFG_RING_MINUTES:   cfg_reg.ring_minutes   <= cfg_data;
                CFG_SNOOZE_MINUTES: cfg_reg.snooze_minutes <= cfg_data;
                default:            ;  // unmapped index: write dropped
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.req_type     <= req_t'(s_tuser);
            in_item_reg.now_hour     <= s_tdata[4:0];
            in_item_reg.now_minute   <= s_tdata[10:5];
            in_item_reg.wanted_sound <= s_tdata[18:11];
            in_item_reg.random_sound <= s_tdata[26:19];
            in_item_reg.sound_busy   <= s_tdata[27];
        end
    end

    asc_step u_step
    (
        .cfg  (cfg_reg),
        .cur  (ctx_reg),
        .item (in_item_reg),
        .nxt  (ctx_next),
        .res  (res_next)
    );

    // context commits only when the transaction leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.phase          <= PH_OFF;
            ctx_reg.ring_timer     <= 14'd0;
            ctx_reg.snooze_timer   <= 14'd0;
            ctx_reg.tries_left     <= 8'd0;
            ctx_reg.predelay_count <= 2'd0;
            ctx_reg.chosen_sound   <= 8'd0;
            ctx_reg.led_duty       <= 10'd0;
        end
        else if (process)
        begin
            ctx_reg <= ctx_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
            out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // LED must be at full whenever the reported phase is ringing or predelay
    a_led_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((out_res_reg.alarm_state == PH_ON) ||
                     (out_res_reg.alarm_state == PH_INIT))
        |-> (out_res_reg.led_level == LED_FULL))
        else $error("LED not full while ringing or in predelay");

    // sound start, time announce and bright display only come out in the ringing phase
    a_ring_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_res_reg.start_sound || out_res_reg.announce_time ||
                     out_res_reg.force_bright)
        |-> (out_res_reg.alarm_state == PH_ON))
        else $error("ring command outside ringing phase");

    // a draining output must never back-pressure the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // a result transaction waits in place until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
